/* hw/rtl/msrr_pkg.sv */
// ----------------------------------------------------------------------------
// msrr_pkg
// Types and constants shared by the motor speed ramp and reversal core.
// ----------------------------------------------------------------------------
`default_nettype none

package msrr_pkg;

    localparam int unsigned SPEED_W   = 8;
    localparam int unsigned ELAPSED_W = 17;
    localparam int unsigned STEP_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
    localparam logic [SPEED_W-1:0]   FULL_DUTY   = 8'd255;

    localparam logic [STEP_W-1:0]  ACCEL_RESET = 16'd20;
    localparam logic [STEP_W-1:0]  DECEL_RESET = 16'd20;
    localparam logic [SPEED_W-1:0] MAX_RESET   = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_STEP = 2'd0,
        REG_DECEL_STEP = 2'd1,
        REG_MAX_SPEED  = 2'd2
    } t_msrr_reg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_BRAKE = 2'd2
    } t_msrr_cmd;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_FULL = 2'd1,
        MODE_PWM  = 2'd2
    } t_msrr_mode;

    typedef struct packed {
        logic [1:0] command;
        logic       direction;
    } t_msrr_in;

    typedef struct packed {
        logic [SPEED_W-1:0] duty;
        logic [1:0]         drive_mode;
        logic               motor_direction;
        logic               running;
    } t_msrr_out;

    typedef struct packed {
        logic [SPEED_W-1:0]   speed;
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic                 run_state;
        logic                 applied_direction;
        logic                 wanted_direction;
    } t_msrr_state;

    typedef struct packed {
        logic [STEP_W-1:0]  accel_step_ms;
        logic [STEP_W-1:0]  decel_step_ms;
        logic [SPEED_W-1:0] max_speed;
    } t_msrr_cfg;

endpackage

`default_nettype wire

/* hw/rtl/msrr_step.sv */
// ----------------------------------------------------------------------------
// msrr_step
// Next state and result for one command, from the current state and settings.
// ----------------------------------------------------------------------------
`default_nettype none

module msrr_step
    import msrr_pkg::*;
(
    input  wire t_msrr_state i_state,
    input  wire t_msrr_cfg   i_cfg,
    input  wire t_msrr_in    i_item,
    output t_msrr_state      o_state,
    output t_msrr_out        o_result
);

    t_msrr_state tick_st;
    t_msrr_state nxt;
    logic        may_run;

    always_comb begin
        tick_st = i_state;
        may_run = 1'b1;
        if (tick_st.elapsed_ms != ELAPSED_MAX) begin
            tick_st.elapsed_ms = tick_st.elapsed_ms + 1'b1;
        end
        if (tick_st.run_state && (tick_st.applied_direction != tick_st.wanted_direction)) begin
            tick_st.run_state = 1'b0;
        end
        if (!tick_st.run_state) begin
            may_run = 1'b0;
            if (tick_st.speed != '0) begin
                if (tick_st.elapsed_ms > {1'b0, i_cfg.decel_step_ms}) begin
                    tick_st.elapsed_ms = '0;
                    tick_st.speed      = tick_st.speed - 1'b1;
                end
            end else if (tick_st.applied_direction != tick_st.wanted_direction) begin
                tick_st.applied_direction = tick_st.wanted_direction;
                tick_st.run_state         = 1'b1;
                may_run                   = 1'b1;
            end
        end
        if (may_run && tick_st.run_state) begin
            if (tick_st.speed < i_cfg.max_speed) begin
                if (tick_st.elapsed_ms > {1'b0, i_cfg.accel_step_ms}) begin
                    tick_st.elapsed_ms = '0;
                    tick_st.speed      = tick_st.speed + 1'b1;
                end
            end else if (tick_st.speed > i_cfg.max_speed) begin
                if (tick_st.elapsed_ms > {1'b0, i_cfg.decel_step_ms}) begin
                    tick_st.elapsed_ms = '0;
                    tick_st.speed      = tick_st.speed - 1'b1;
                end
            end
        end
    end

    always_comb begin
        nxt = i_state;
        case (i_item.command)
            CMD_TICK: begin
                nxt = tick_st;
            end
            CMD_MOVE: begin
                nxt.wanted_direction = i_item.direction;
                nxt.run_state        = 1'b1;
            end
            CMD_BRAKE: begin
                nxt.run_state        = 1'b0;
                nxt.wanted_direction = i_state.applied_direction;
            end
            default: begin
                nxt = i_state;
            end
        endcase
    end

    always_comb begin
        o_state                  = nxt;
        o_result.duty            = nxt.speed;
        o_result.motor_direction = nxt.applied_direction;
        o_result.running         = nxt.run_state;
        if (nxt.speed == '0) begin
            o_result.drive_mode = MODE_OFF;
        end else if (nxt.speed == FULL_DUTY) begin
            o_result.drive_mode = MODE_FULL;
        end else begin
            o_result.drive_mode = MODE_PWM;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/motor_speed_ramp_reverser_core.sv */
// ----------------------------------------------------------------------------
// motor_speed_ramp_reverser_core
// Soft-start speed ramp for a DC motor with reversal through zero speed.
//
//   Channel  Signals                           Moves
//   in       i_in_valid / o_in_ready           one command word
//   out      o_out_valid / i_out_ready         one drive status word
//   cfg      i_cfg_we, i_cfg_index, i_cfg_data one register write
//
// A command word is held in the input register; the step logic then updates
// the motor state and loads the result register, so a word is accepted every
// cycle unless the output stalls; its result is offered from that register.
// Reset clears the motor state and loads the default settings.
// A stalled output holds its result; the input register keeps taking words
// until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_speed_ramp_reverser_core
    import msrr_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire t_msrr_in        i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output t_msrr_out            o_out_data,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DAT_W-1:0]  i_cfg_data
);

    logic        r_in_valid;
    t_msrr_in    r_in_data;
    logic        r_out_valid;
    t_msrr_out   r_out_data;
    t_msrr_state r_state;
    t_msrr_cfg   r_cfg;

    t_msrr_state n_state;
    t_msrr_out   n_out_data;
    logic        advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    msrr_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in_data),
        .o_state  (n_state),
        .o_result (n_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_step_ms <= ACCEL_RESET;
            r_cfg.decel_step_ms <= DECEL_RESET;
            r_cfg.max_speed     <= MAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ACCEL_STEP: r_cfg.accel_step_ms <= i_cfg_data;
                REG_DECEL_STEP: r_cfg.decel_step_ms <= i_cfg_data;
                REG_MAX_SPEED: begin
                    if (i_cfg_data[SPEED_W-1:0] == '0) begin
                        r_cfg.max_speed <= SPEED_W'(1);
                    end else begin
                        r_cfg.max_speed <= i_cfg_data[SPEED_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_speed_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(r_state.speed) |->
            $past(advance) &&
            ((r_state.speed == $past(r_state.speed) + 8'd1) ||
             (r_state.speed == $past(r_state.speed) - 8'd1)))
        else $error("speed changed without a command or by more than one");

    a_mode_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            ((r_out_data.drive_mode == MODE_OFF) == (r_out_data.duty == '0)))
        else $error("drive mode off does not match zero duty");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_out_valid && !i_out_ready)
        else $error("input stalled while the pipeline can move");
`endif

endmodule

`default_nettype wire
